/* rtl/itmswo_pkg.sv */
// Shared types and constants for the ITM/SWO trace packet parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package itmswo_pkg;

    localparam int BYTE_W    = 8;
    localparam int CH_IDX_W  = 5;
    localparam int CHAN_W    = 10;
    localparam int STAMP_W   = 32;
    localparam int TALLY_W   = 16;
    localparam int SBC_W     = 3;

    // Header decode patterns
    localparam logic [BYTE_W-1:0] HDR_GLB_MASK = 8'hDF;
    localparam logic [BYTE_W-1:0] HDR_GLB_CODE = 8'h94;
    localparam logic [BYTE_W-1:0] HDR_EXT_MASK = 8'h0B;
    localparam logic [BYTE_W-1:0] HDR_EXT_CODE = 8'h08;
    localparam logic [BYTE_W-1:0] VALUE_TRUE   = 8'hAA;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = 16'hFFFF;

    // Command queue between the front and back ends
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    typedef enum logic {
        CMD_PAIR  = 1'b0,
        CMD_CLOSE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [CH_IDX_W-1:0]   ch;
        logic [BYTE_W-1:0]     value;
        logic [STAMP_W-1:0]    stamp;
        logic [TALLY_W-1:0]    tally;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/itm_swo_trace_packet_parser_core.sv */
// Top level of the ITM/SWO trace packet parser: front end, command queue, back end.
// Depends on itmswo_pkg, itmswo_front, itmswo_cmdq, itmswo_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | trace_byte
//  result   | empty / pop      | channel_bits, time_delta, bad_opcode_count
//
// The front end takes one trace byte per cycle while the command queue has room.
// A queued channel pair goes straight into the pending memory; a closing timestamp
// walks the pending pairs, one memory read and one apply per pair, then loads the
// result, since the pending memory has a single read port.
// full rises when the four-entry command queue backs up behind a long close.
// Reset clears all control state and the channel vector at once; no sweep.
// The result register holds its transfer until pop; the back end waits on it.
`default_nettype none

module itm_swo_trace_packet_parser_core #(
    parameter int NUM_CHANNELS    = 10,
    parameter int PENDING_DEPTH   = 16,
    parameter int STAMP_MAX_BYTES = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [itmswo_pkg::BYTE_W-1:0]  trace_byte,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [itmswo_pkg::CHAN_W-1:0]       channel_bits,
    output logic [itmswo_pkg::STAMP_W-1:0]      time_delta,
    output logic [itmswo_pkg::TALLY_W-1:0]      bad_opcode_count
);
    import itmswo_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_valid;
    logic in_valid;
    logic q_empty;
    logic q_pop;

    // Accept a byte only when the queue can take whatever command it makes
    assign in_valid = push && !full;

    itmswo_front #(
        .PENDING_DEPTH   (PENDING_DEPTH),
        .STAMP_MAX_BYTES (STAMP_MAX_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (trace_byte),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    itmswo_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    itmswo_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (head_cmd),
        .cmd_empty        (q_empty),
        .cmd_pop          (q_pop),
        .pop              (pop),
        .empty            (empty),
        .channel_bits     (channel_bits),
        .time_delta       (time_delta),
        .bad_opcode_count (bad_opcode_count)
    );

endmodule

`default_nettype wire

/* rtl/itmswo_front.sv */
// Front end: parses one trace byte per cycle and issues pair/close commands.
// Depends on itmswo_pkg.
`default_nettype none

module itmswo_front #(
    parameter int PENDING_DEPTH   = 16,
    parameter int STAMP_MAX_BYTES = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [itmswo_pkg::BYTE_W-1:0] in_byte,
    output itmswo_pkg::cmd_t                 cmd,
    output logic                             cmd_valid
);
    import itmswo_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    localparam logic [2:0] M_HUNT  = 3'd0;
    localparam logic [2:0] M_IDLE  = 3'd1;
    localparam logic [2:0] M_VALUE = 3'd2;
    localparam logic [2:0] M_STAMP = 3'd3;
    localparam logic [2:0] M_SKIP  = 3'd4;

    logic [2:0]          mode_reg, mode_next;
    logic [CH_IDX_W-1:0] ch_hold_reg, ch_hold_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STAMP_W-1:0]  accum_reg, accum_next;
    logic [SBC_W-1:0]    sbc_reg, sbc_next;
    logic [TALLY_W-1:0]  tally_reg, tally_next;

    logic               is_src, is_loc, is_glb, is_ext, take_hdr;
    logic [4:0]         sh;
    logic [STAMP_W-1:0] accum_add;

    assign is_src   = in_byte[0];
    assign is_loc   = (in_byte[3:0] == 4'd0) && (in_byte[6:4] != 3'd0);
    assign is_glb   = (in_byte & HDR_GLB_MASK) == HDR_GLB_CODE;
    assign is_ext   = (in_byte & HDR_EXT_MASK) == HDR_EXT_CODE;
    assign take_hdr = (mode_reg != M_HUNT) || is_src || is_loc || is_glb;

    // 7 bits per continuation byte
    assign sh = 5'({2'b00, sbc_reg} * 5'd7);
    assign accum_add = (sbc_reg < SBC_W'(STAMP_MAX_BYTES))
                     ? (accum_reg | ({25'd0, in_byte[6:0]} << sh)) : accum_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        ch_hold_next = ch_hold_reg;
        cnt_next     = cnt_reg;
        accum_next   = accum_reg;
        sbc_next     = sbc_reg;
        tally_next   = tally_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = CMD_PAIR;
        cmd.ch       = ch_hold_reg;
        cmd.value    = in_byte;
        cmd.stamp    = accum_add;
        cmd.tally    = tally_reg;
        if (in_valid)
        begin
            unique case (mode_reg)
                M_VALUE:
                begin
                    // drop the pair when the pending list is full
                    if (cnt_reg < CNT_W'(PENDING_DEPTH))
                    begin
                        cmd_valid = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    mode_next = M_IDLE;
                end
                M_STAMP:
                begin
                    accum_next = accum_add;
                    if (sbc_reg < SBC_W'(STAMP_MAX_BYTES))
                        sbc_next = sbc_reg + 1'b1;
                    if (!in_byte[7])
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = CMD_CLOSE;
                        cnt_next  = '0;
                        mode_next = M_IDLE;
                    end
                end
                M_SKIP:
                    mode_next = in_byte[7] ? M_SKIP : M_IDLE;
                default:
                begin
                    if (take_hdr)
                    begin
                        if (is_src)
                        begin
                            ch_hold_next = in_byte[7:3];
                            mode_next    = M_VALUE;
                        end
                        else if (is_loc || is_glb)
                        begin
                            accum_next = '0;
                            sbc_next   = '0;
                            if (in_byte[7])
                                mode_next = M_STAMP;
                            else
                            begin
                                cmd_valid = 1'b1;
                                cmd.kind  = CMD_CLOSE;
                                cmd.stamp = {29'd0, in_byte[6:4]};
                                cnt_next  = '0;
                                mode_next = M_IDLE;
                            end
                        end
                        else
                        begin
                            if (!is_ext && tally_reg != TALLY_MAX)
                                tally_next = tally_reg + 1'b1;
                            mode_next = in_byte[7] ? M_SKIP : M_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_HUNT;
            cnt_reg   <= '0;
            accum_reg <= '0;
            sbc_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            accum_reg <= accum_next;
            sbc_reg   <= sbc_next;
            tally_reg <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_hold_reg <= ch_hold_next;
    end

endmodule

`default_nettype wire

/* rtl/itmswo_cmdq.sv */
// Short command queue decoupling the front end from the back end.
// Depends on itmswo_pkg.
`default_nettype none

module itmswo_cmdq (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  itmswo_pkg::cmd_t wr_data,
    output logic            full,
    input  wire logic       rd_en,
    output itmswo_pkg::cmd_t rd_data,
    output logic            empty
);
    import itmswo_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  do_wr, do_rd;

    assign full    = cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/itmswo_back.sv */
// Back end: stores pending channel pairs, applies them on a close, drives results.
// Depends on itmswo_pkg.
`default_nettype none

module itmswo_back #(
    parameter int NUM_CHANNELS  = 10,
    parameter int PENDING_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  itmswo_pkg::cmd_t                   cmd,
    input  wire logic                          cmd_empty,
    output logic                               cmd_pop,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [itmswo_pkg::CHAN_W-1:0]      channel_bits,
    output logic [itmswo_pkg::STAMP_W-1:0]     time_delta,
    output logic [itmswo_pkg::TALLY_W-1:0]     bad_opcode_count
);
    import itmswo_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int ENT_W = CH_IDX_W + BYTE_W;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_AP   = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    logic [ENT_W-1:0]        pend_mem [PENDING_DEPTH];
    logic [ENT_W-1:0]        rd_reg;
    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [NUM_CHANNELS-1:0] bits_reg, bits_next;
    logic [STAMP_W-1:0]      stamp_reg;
    logic [TALLY_W-1:0]      tally_reg;
    logic                    out_valid_reg;
    logic [CHAN_W-1:0]       bits_out;
    logic                    out_load, mem_wr, take_close;

    assign empty = !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        cmd_pop    = 1'b0;
        out_load   = 1'b0;
        mem_wr     = 1'b0;
        take_close = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_PAIR)
                    begin
                        mem_wr    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        take_close = 1'b1;
                        idx_next   = '0;
                        state_next = (fill_reg == '0) ? B_EMIT : B_RD;
                    end
                end
            end
            B_RD:
                state_next = B_AP;
            B_AP:
            begin
                // out-of-range channels match no bit and drop out here
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (rd_reg[ENT_W-1:BYTE_W] == CH_IDX_W'(i))
                        bits_next[i] = rd_reg[BYTE_W-1:0] == VALUE_TRUE;
                end
                if (idx_reg + 1'b1 == fill_reg)
                begin
                    fill_next  = '0;
                    state_next = B_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            default:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
        endcase
    end

    // Fit the channel vector to the fixed result width
    generate
        for (genvar g = 0; g < CHAN_W; g++)
        begin : g_bits
            if (g < NUM_CHANNELS)
            begin : g_live
                assign bits_out[g] = bits_reg[g];
            end
            else
            begin : g_zero
                assign bits_out[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            pend_mem[fill_reg[IDX_W-1:0]] <= {cmd.ch, cmd.value};
        rd_reg <= pend_mem[idx_reg[IDX_W-1:0]];
        if (take_close)
        begin
            stamp_reg <= cmd.stamp;
            tally_reg <= cmd.tally;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            fill_reg         <= '0;
            idx_reg          <= '0;
            bits_reg         <= '0;
            out_valid_reg    <= 1'b0;
            channel_bits     <= '0;
            time_delta       <= '0;
            bad_opcode_count <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            bits_reg  <= bits_next;
            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                channel_bits     <= bits_out;
                time_delta       <= stamp_reg;
                bad_opcode_count <= tally_reg;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/itmswo_checker.sv */
// Port-level checker for the ITM/SWO trace packet parser, bound to the top level.
// No package dependency.
`default_nettype none

module itmswo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic [9:0]  channel_bits,
    input wire logic [31:0] time_delta,
    input wire logic [15:0] bad_opcode_count
);

    // Hold no result and take input freely while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("result or full flag seen during reset");

    // Hold a waiting result until it is transferred
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(time_delta) && $stable(channel_bits)))
        else $error("waiting result changed before transfer");

    // The opcode tally only grows between resets
    a_tally_grow: assert property (@(posedge clk)
        (rst_n && $past(rst_n)) |-> (bad_opcode_count >= $past(bad_opcode_count)))
        else $error("bad opcode count decreased");

    // A result freshly loaded after a transfer keeps the tally nondecreasing too
    a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> ($past(bad_opcode_count) <= bad_opcode_count))
        else $error("tally dropped across a transfer");

endmodule

bind itm_swo_trace_packet_parser_core itmswo_checker u_chk (.*);

`default_nettype wire

/* sim/itm_swo_trace_packet_parser_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the ITM/SWO trace packet parser: SWO byte streams in, channel frames out.
// Depends on itmswo_pkg and itm_swo_trace_packet_parser_core; holds its own scoreboard class.

module itm_swo_trace_packet_parser_core_test;

    import itmswo_pkg::*;

    localparam int NUM_CHANNELS    = 10;
    localparam int PENDING_DEPTH   = 16;
    localparam int STAMP_MAX_BYTES = 5;

    // Bit 7 of a packet byte says another byte follows; the low seven carry payload.
    localparam logic [BYTE_W-1:0] CONT_BIT     = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7F;

    // Settle time after the last frame.
    localparam int DRAIN_CYCLES = 200;

    typedef enum logic [2:0] {
        PM_HUNT,
        PM_IDLE,
        PM_VALUE,
        PM_STAMP,
        PM_SKIP
    } parse_mode_e;

    typedef enum logic [1:0] {
        HK_SOURCE,
        HK_STAMP,
        HK_EXTENSION,
        HK_UNKNOWN
    } hdr_class_e;

    typedef struct packed {
        logic [CHAN_W-1:0]  chans;
        logic [STAMP_W-1:0] stamp;
        logic [TALLY_W-1:0] tally;
    } swo_frame_t;

    // Tracks the parser's state byte by byte and holds the frames still owed by the block.
    class swo_frame_board;
        parse_mode_e        mode;
        logic [4:0]         q_chan [PENDING_DEPTH];
        logic [BYTE_W-1:0]  q_val  [PENDING_DEPTH];
        int unsigned        q_count;
        logic [STAMP_W-1:0] stamp;
        int unsigned        stamp_bytes;
        logic [CHAN_W-1:0]  chan_state;
        logic [TALLY_W-1:0] tally;
        swo_frame_t         due_frames[$];
        int unsigned        failures;

        function new();
            mode        = PM_HUNT;
            q_count     = 0;
            stamp       = '0;
            stamp_bytes = 0;
            chan_state  = '0;
            tally       = '0;
            failures    = 0;
        endfunction

        static function hdr_class_e header_class(logic [BYTE_W-1:0] b);
            if (b[0])
                return HK_SOURCE;
            if ((b[3:0] == 4'h0 && b[6:4] != 3'b000) || (b & HDR_GLB_MASK) == HDR_GLB_CODE)
                return HK_STAMP;
            if ((b & HDR_EXT_MASK) == HDR_EXT_CODE)
                return HK_EXTENSION;
            return HK_UNKNOWN;
        endfunction

        function int unsigned waiting();
            return due_frames.size();
        endfunction

        // Apply the queued channel pairs in order, then owe one frame.
        function void close_stamp_packet(logic [STAMP_W-1:0] value);
            swo_frame_t f;
            for (int unsigned i = 0; i < q_count; i++) begin
                if (q_chan[i] < NUM_CHANNELS)
                    chan_state[q_chan[i]] = (q_val[i] == VALUE_TRUE);
            end
            q_count  = 0;
            f.chans  = chan_state;
            f.stamp  = value;
            f.tally  = tally;
            due_frames.push_back(f);
        endfunction

        function void decode_header(logic [BYTE_W-1:0] b);
            case (header_class(b))
                HK_SOURCE:
                begin
                    if (q_count < PENDING_DEPTH)
                        q_chan[q_count] = b[7:3];
                    mode = PM_VALUE;
                end
                HK_STAMP:
                begin
                    stamp       = '0;
                    stamp_bytes = 0;
                    if (b[7])
                        mode = PM_STAMP;
                    else
                    begin
                        mode = PM_IDLE;
                        close_stamp_packet(STAMP_W'(b[6:4]));
                    end
                end
                HK_EXTENSION:
                    mode = b[7] ? PM_SKIP : PM_IDLE;
                default:
                begin
                    if (tally != TALLY_MAX)
                        tally++;
                    mode = b[7] ? PM_SKIP : PM_IDLE;
                end
            endcase
        endfunction

        // Note one accepted input transfer.
        function void take_byte(logic [BYTE_W-1:0] b);
            hdr_class_e hc;
            hc = header_class(b);
            case (mode)
                PM_HUNT:
                begin
                    if (hc == HK_SOURCE || hc == HK_STAMP)
                        decode_header(b);
                end
                PM_VALUE:
                begin
                    if (q_count < PENDING_DEPTH)
                    begin
                        q_val[q_count] = b;
                        q_count++;
                    end
                    mode = PM_IDLE;
                end
                PM_STAMP:
                begin
                    if (stamp_bytes < STAMP_MAX_BYTES)
                    begin
                        stamp = stamp | (STAMP_W'(b & PAYLOAD_MASK) << (7 * stamp_bytes));
                        stamp_bytes++;
                    end
                    if (!b[7])
                    begin
                        mode = PM_IDLE;
                        close_stamp_packet(stamp);
                    end
                end
                PM_SKIP:
                begin
                    if (!b[7])
                        mode = PM_IDLE;
                end
                default:
                    decode_header(b);
            endcase
        endfunction

        // Check one accepted result transfer against the oldest owed frame.
        function void match_result(logic [CHAN_W-1:0] ch, logic [STAMP_W-1:0] td,
                                   logic [TALLY_W-1:0] cnt);
            swo_frame_t want;
            if (due_frames.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual channel_bits=%h time_delta=%h bad_opcode_count=%h",
                         $time, ch, td, cnt);
                failures++;
                return;
            end
            want = due_frames.pop_front();
            if (ch !== want.chans)
            begin
                $display("%0t: channel_bits mismatch: expected %h actual %h", $time, want.chans, ch);
                failures++;
            end
            if (td !== want.stamp)
            begin
                $display("%0t: time_delta mismatch: expected %h actual %h", $time, want.stamp, td);
                failures++;
            end
            if (cnt !== want.tally)
            begin
                $display("%0t: bad_opcode_count mismatch: expected %h actual %h",
                         $time, want.tally, cnt);
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   trace_byte;
    logic                pop;
    logic                empty;
    logic [CHAN_W-1:0]   channel_bits;
    logic [STAMP_W-1:0]  time_delta;
    logic [TALLY_W-1:0]  bad_opcode_count;

    swo_frame_board      sb;
    int unsigned         tx_idle_pct;
    int unsigned         rx_stall_pct;
    int unsigned         bytes_sent;

    itm_swo_trace_packet_parser_core #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .PENDING_DEPTH   (PENDING_DEPTH),
        .STAMP_MAX_BYTES (STAMP_MAX_BYTES)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .trace_byte       (trace_byte),
        .pop              (pop),
        .empty            (empty),
        .channel_bits     (channel_bits),
        .time_delta       (time_delta),
        .bad_opcode_count (bad_opcode_count)
    );

    always #5 clk = ~clk;

    // Receiver: decide pop on the falling edge, one assignment per step.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= rx_stall_pct);

    // Check every result transfer at the rising edge it completes on.
    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.match_result(channel_bits, time_delta, bad_opcode_count);

    // Offer one byte and hold it until the block takes the transfer.
    // push stays high past acceptance so back-to-back bytes need no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        trace_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    // Drop push on the next falling edge; call before any pause in the stream.
    task automatic stop_input();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.waiting() != 0)
            @(posedge clk);
    endtask

    // An extension or unknown packet, with a random skipped tail when bit 7 is set.
    task automatic send_aside();
        logic [BYTE_W-1:0] b;
        logic              cont;
        cont = 1'($urandom);
        if ($urandom_range(1) == 0)
            b = {cont, 3'($urandom), 1'b1, 1'($urandom), 2'b00};
        else
        begin
            do
                b = {cont, 7'($urandom)};
            while (swo_frame_board::header_class(b) != HK_UNKNOWN);
        end
        send_byte(b);
        if (cont)
        begin
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom) | CONT_BIT);
            send_byte(8'($urandom) & PAYLOAD_MASK);
        end
    endtask

    // One well-formed run: channel pairs, maybe a stray packet, then a closing timestamp.
    // About one run in ten is raw noise instead, which also breaks the next run's framing.
    task automatic send_group();
        int unsigned       n_pairs;
        int unsigned       n_cont;
        logic [4:0]        ch;
        logic [BYTE_W-1:0] b;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom));
            return;
        end
        // Mostly short queues; now and then run past the pending depth to hit overflow.
        n_pairs = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        for (int unsigned i = 0; i < n_pairs; i++)
        begin
            if ($urandom_range(11) == 0)
                send_aside();
            ch = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(NUM_CHANNELS - 1));
            send_byte({ch, 2'($urandom), 1'b1});
            send_byte(($urandom_range(1) == 0) ? VALUE_TRUE : 8'($urandom));
        end
        if ($urandom_range(5) == 0)
            send_aside();
        case ($urandom_range(2))
            0: b = {1'b0, 3'($urandom_range(1, 7)), 4'h0};
            1: b = {1'b1, 3'($urandom_range(1, 7)), 4'h0};
            default: b = HDR_GLB_CODE | (8'($urandom_range(1)) << 5);
        endcase
        send_byte(b);
        if (b[7])
        begin
            // Occasionally run longer than the stamp accepts.
            n_cont = ($urandom_range(4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
            for (int unsigned i = 0; i < n_cont; i++)
            begin
                b    = 8'($urandom);
                b[7] = (i != n_cont - 1);
                send_byte(b);
            end
        end
    endtask

    // Hard stop if the block hangs or withholds a frame.
    initial
    begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [BYTE_W-1:0] directed [$];
        int unsigned       phase_end;

        sb           = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        trace_byte   = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        bytes_sent   = 0;

        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed stream, opening in sync hunt:
        //  - a zero byte, a lone continuation and an extension header are ignored in hunt
        //  - channel 9 and channel 0 set, an out-of-range channel 31 is ignored
        //  - a lone local stamp with all three value bits set closes the first frame
        //  - channel 9 cleared; a local stamp with one payload byte decodes it, not the header bits
        //  - an unknown header with a skipped tail, an extension with a tail, a bare unknown
        //  - a global stamp with a zero payload, then one running past the byte limit
        directed = '{8'h00, 8'h80, 8'h08,
                     8'h49, 8'hAA, 8'h01, 8'hAA, 8'hF9, 8'hAA,
                     8'h70,
                     8'h4D, 8'h55, 8'hC0, 8'h05,
                     8'h82, 8'h94, 8'h00, 8'h88, 8'h7F, 8'h02,
                     8'h94, 8'h00,
                     8'hB4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        foreach (directed[i])
            send_byte(directed[i]);

        // Random runs in four handshake regimes. Drain between phases so the
        // sender sits idle while the block works off every owed frame.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            phase_end = bytes_sent + 380;
            while (bytes_sent < phase_end)
                send_group();
            stop_input();
            wait_drained();
        end

        // Close out with a lone stamp, then a few runs with both sides idling.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_byte(8'h10);
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        repeat (8)
            send_group();

        stop_input();
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/itmswo_pkg.sv
rtl/itmswo_front.sv
rtl/itmswo_cmdq.sv
rtl/itmswo_back.sv
rtl/itm_swo_trace_packet_parser_core.sv
rtl/itmswo_checker.sv
sim/itm_swo_trace_packet_parser_core_test.sv
